// ----- sv/ws2812_frame_encoder_assert.svh -----
// ----------------------------------------------------------------------------
// WS2812 frame encoder assertion macros
// Shorthand for the clocked checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef WS2812_FRAME_ENCODER_ASSERT_SVH
`define WS2812_FRAME_ENCODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WSFE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define WSFE_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/wsfe_pkg.sv -----
// ----------------------------------------------------------------------------
// wsfe_pkg
// Types, constants and the chip encoder shared by the frame encoder modules.
// ----------------------------------------------------------------------------
package wsfe_pkg;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam int DIM_W = 5;
  localparam logic [DIM_W-1:0] DIM_MAX = 5'd16;
  localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

  // Register index as decoded from paddr bit 2.
  localparam logic REG_WIDTH = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam int CHIPS_PER_BIT = 3;
  localparam logic [CHIPS_PER_BIT-1:0] CHIP_ONE = 3'b110;
  localparam logic [CHIPS_PER_BIT-1:0] CHIP_ZERO = 3'b100;
  localparam int BYTES_PER_PIXEL = 9;

  // v / 9 == (v * 7282) >> 16 for every v below 4096.
  localparam int RECIP_W = 25;
  localparam logic [RECIP_W-1:0] RECIP_NINE = 25'd7282;
  localparam int RECIP_SHIFT = 16;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_SWAP  = 2'd2,
    OP_READ  = 2'd3
  } wsfe_op_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_ENC,
    S_CLEAR,
    S_DONE
  } wsfe_state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  pos_x;
    logic [3:0]  pos_y;
    logic [23:0] colour;
    logic [11:0] byte_index;
  } in_item_t;

  typedef struct packed {
    logic       status;
    logic [7:0] read_byte;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic div;
    logic enc;
    logic clr;
    logic init_clr;
    logic out_load;
  } wsfe_cmd_t;

  typedef struct packed {
    wsfe_op_t op;
    logic     clr_last;
    logic     out_free;
  } wsfe_stat_t;

  // One byte (0..8) of the 72-chip stream of a pixel, sent green, red, blue.
  function automatic logic [7:0] encode_byte(input logic [23:0] colour,
                                             input logic [3:0] sel);
    logic [23:0] grb;
    logic [71:0] stream;
    logic [8:0][7:0] bytes;
    logic [3:0] idx;
    grb = {colour[15:8], colour[23:16], colour[7:0]};
    stream = '0;
    for (int t = 0; t < 24; t++) begin
      stream[71 - CHIPS_PER_BIT * t -: CHIPS_PER_BIT] = grb[23 - t] ? CHIP_ONE : CHIP_ZERO;
    end
    bytes = stream;
    idx = 4'(BYTES_PER_PIXEL - 1) - sel;
    if (sel > 4'(BYTES_PER_PIXEL - 1)) begin
      return 8'd0;
    end
    return bytes[idx];
  endfunction

endpackage

// ----- sv/wsfe_ctrl.sv -----
// ----------------------------------------------------------------------------
// wsfe_ctrl
// Sequencer that steps one command at a time through the datapath.
// ----------------------------------------------------------------------------
module wsfe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  wsfe_pkg::wsfe_stat_t stat_i,
  output wsfe_pkg::wsfe_cmd_t  cmd_o
);

  wsfe_pkg::wsfe_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wsfe_pkg::S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wsfe_pkg::S_INIT: begin
        if (stat_i.clr_last) state_nxt = wsfe_pkg::S_IDLE;
      end
      wsfe_pkg::S_IDLE: begin
        if (in_valid) state_nxt = wsfe_pkg::S_EXEC;
      end
      wsfe_pkg::S_EXEC: begin
        case (stat_i.op)
          wsfe_pkg::OP_CLEAR: state_nxt = wsfe_pkg::S_CLEAR;
          wsfe_pkg::OP_READ:  state_nxt = wsfe_pkg::S_DIV;
          default:            state_nxt = wsfe_pkg::S_DONE;
        endcase
      end
      wsfe_pkg::S_DIV:   state_nxt = wsfe_pkg::S_ENC;
      wsfe_pkg::S_ENC:   state_nxt = wsfe_pkg::S_DONE;
      wsfe_pkg::S_CLEAR: begin
        if (stat_i.clr_last) state_nxt = wsfe_pkg::S_DONE;
      end
      wsfe_pkg::S_DONE: begin
        if (stat_i.out_free) state_nxt = wsfe_pkg::S_IDLE;
      end
      default: state_nxt = wsfe_pkg::S_INIT;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready = 1'b0;
    case (state_r)
      wsfe_pkg::S_INIT:  cmd_o.init_clr = 1'b1;
      wsfe_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd_o.load = in_valid;
      end
      wsfe_pkg::S_EXEC:  cmd_o.exec = 1'b1;
      wsfe_pkg::S_DIV:   cmd_o.div = 1'b1;
      wsfe_pkg::S_ENC:   cmd_o.enc = 1'b1;
      wsfe_pkg::S_CLEAR: cmd_o.clr = 1'b1;
      wsfe_pkg::S_DONE:  cmd_o.out_load = stat_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ----- sv/wsfe_dp.sv -----
// ----------------------------------------------------------------------------
// wsfe_dp
// Frame stores, range checks, byte index split and chip encoder.
// ----------------------------------------------------------------------------
module wsfe_dp #(
  parameter int MAX_PIXELS = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wsfe_pkg::in_item_t            in_data,
  input  wsfe_pkg::wsfe_cmd_t           cmd_i,
  output wsfe_pkg::wsfe_stat_t          stat_o,
  input  logic [wsfe_pkg::DIM_W-1:0]    width_reg,
  input  logic [wsfe_pkg::DIM_W-1:0]    height_reg,
  output logic                          out_valid,
  input  logic                          out_ready,
  output wsfe_pkg::out_item_t           out_data
);

  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int PW = $clog2(MAX_PIXELS + 1);
  localparam int CMP_W = (PW > 9) ? PW : 9;

  logic [23:0] mem_a [MAX_PIXELS];
  logic [23:0] mem_b [MAX_PIXELS];
  logic [23:0] rdata_a_r, rdata_b_r;

  wsfe_pkg::in_item_t  item_r;
  wsfe_pkg::out_item_t out_data_r;
  logic                out_valid_r;
  logic                draw_sel_r;
  logic [AW-1:0]       clr_cnt_r;
  logic [wsfe_pkg::RECIP_W-1:0] prod_r;
  logic                res_status_r;
  logic [7:0]          res_byte_r;
  logic [3:0]          rem_r;
  logic                rd_ok_r;

  wsfe_pkg::wsfe_op_t  op;
  logic [wsfe_pkg::DIM_W-1:0] w_eff, h_eff;
  logic [8:0]          num;
  logic [CMP_W-1:0]    num_ext;
  logic                set_err, set_we;
  logic [9:0]          area;
  logic [12:0]         frame_len;
  logic                len_err;
  logic [11:0]         idx_m1;
  logic [8:0]          pix;
  logic [CMP_W-1:0]    pix_ext;
  logic                pix_err;
  logic [12:0]         rem_full;
  logic                sweep;
  logic                we_a, we_b;
  logic [AW-1:0]       waddr, raddr;
  logic [23:0]         wdata;
  logic [23:0]         xmit_word;

  assign op = wsfe_pkg::wsfe_op_t'(item_r.cmd);
  assign w_eff = (width_reg > wsfe_pkg::DIM_MAX) ? wsfe_pkg::DIM_MAX : width_reg;
  assign h_eff = (height_reg > wsfe_pkg::DIM_MAX) ? wsfe_pkg::DIM_MAX : height_reg;

  // Pixel write check.
  assign num = 9'(item_r.pos_x) + 9'(item_r.pos_y) * 9'(w_eff);
  assign num_ext = CMP_W'(num);
  assign set_err = ({1'b0, item_r.pos_x} >= w_eff) || ({1'b0, item_r.pos_y} >= h_eff) ||
                   (num_ext >= CMP_W'(MAX_PIXELS));
  assign set_we = cmd_i.exec && (op == wsfe_pkg::OP_SET) && !set_err;

  // Frame length is one leading byte plus nine bytes per pixel.
  assign area = 10'(w_eff) * 10'(h_eff);
  assign frame_len = (13'(area) << 3) + 13'(area) + 13'd1;
  assign len_err = (13'(item_r.byte_index) >= frame_len);
  assign idx_m1 = item_r.byte_index - 12'd1;

  // Pixel number and byte within the pixel from the registered product.
  assign pix = prod_r[wsfe_pkg::RECIP_SHIFT +: 9];
  assign pix_ext = CMP_W'(pix);
  assign pix_err = (pix_ext >= CMP_W'(MAX_PIXELS));
  assign rem_full = 13'(idx_m1) - (13'(pix) << 3) - 13'(pix);

  assign sweep = cmd_i.init_clr || cmd_i.clr;
  assign we_a = cmd_i.init_clr || ((cmd_i.clr || set_we) && !draw_sel_r);
  assign we_b = cmd_i.init_clr || ((cmd_i.clr || set_we) && draw_sel_r);
  assign waddr = sweep ? clr_cnt_r : num_ext[AW-1:0];
  assign wdata = sweep ? 24'd0 : item_r.colour;
  assign raddr = pix_ext[AW-1:0];

  always_ff @(posedge clk) begin
    if (we_a) mem_a[waddr] <= wdata;
    if (cmd_i.div) rdata_a_r <= mem_a[raddr];
  end

  always_ff @(posedge clk) begin
    if (we_b) mem_b[waddr] <= wdata;
    if (cmd_i.div) rdata_b_r <= mem_b[raddr];
  end

  assign xmit_word = draw_sel_r ? rdata_a_r : rdata_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draw_sel_r <= 1'b0;
      clr_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd_i.exec && (op == wsfe_pkg::OP_SWAP)) draw_sel_r <= !draw_sel_r;
      if (sweep) begin
        clr_cnt_r <= stat_o.clr_last ? '0 : clr_cnt_r + AW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) item_r <= in_data;
    if (cmd_i.exec) begin
      prod_r <= wsfe_pkg::RECIP_W'(idx_m1) * wsfe_pkg::RECIP_NINE;
      res_byte_r <= 8'd0;
      case (op)
        wsfe_pkg::OP_SET:  res_status_r <= set_err;
        wsfe_pkg::OP_READ: res_status_r <= len_err;
        default:           res_status_r <= 1'b0;
      endcase
    end
    if (cmd_i.div) begin
      rem_r <= rem_full[3:0];
      rd_ok_r <= !res_status_r && (item_r.byte_index != 12'd0) && !pix_err;
      if (!res_status_r && (item_r.byte_index != 12'd0) && pix_err) res_status_r <= 1'b1;
    end
    if (cmd_i.enc) begin
      res_byte_r <= rd_ok_r ? wsfe_pkg::encode_byte(xmit_word, rem_r) : 8'd0;
    end
    if (cmd_i.out_load) begin
      out_data_r.status <= res_status_r;
      out_data_r.read_byte <= res_byte_r;
    end
  end

  assign stat_o.op = op;
  assign stat_o.clr_last = (clr_cnt_r == AW'(MAX_PIXELS - 1));
  assign stat_o.out_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

// ----- sv/ws2812_frame_encoder.sv -----
// ----------------------------------------------------------------------------
// ws2812_frame_encoder
// Double-buffered WS2812B frame store with three-chip SPI byte encoding.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data) takes commands: set pixel, clear
// the draw buffer, swap draw and transmit buffers, or read one encoded byte of
// the transmit frame. Each command yields exactly one transaction on the
// output channel (out_valid/out_ready/out_data) with a status bit and a byte.
// Commands run one at a time. From acceptance to the result being offered,
// set pixel and swap simply execute, a read splits the index by a
// reciprocal multiply, then does a registered frame store read, then encodes,
// and a clear writes one store entry per cycle over all MAX_PIXELS entries.
// The next command is accepted the cycle after a result enters the output
// register; each set pixel command passes the idle, execute and done states.
// After reset both stores are swept to black while in_ready stays low;
// matrix_width and matrix_height are still writable then through the cfg_
// APB port (byte addresses 0 and 4, bit 2 selects).
// The output register holds a result while out_ready is low; the next
// command is accepted and worked on meanwhile, and waits to deliver its own
// result until the register is free.
// ----------------------------------------------------------------------------
module ws2812_frame_encoder #(
  parameter int MAX_PIXELS = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  wsfe_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output wsfe_pkg::out_item_t           out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [wsfe_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [wsfe_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [wsfe_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  logic [wsfe_pkg::DIM_W-1:0] width_r, height_r;
  logic                       cfg_wr;
  wsfe_pkg::wsfe_cmd_t        ctrl_cmd;
  wsfe_pkg::wsfe_stat_t       dp_stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= wsfe_pkg::DIM_RESET;
      height_r <= wsfe_pkg::DIM_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == wsfe_pkg::REG_HEIGHT) begin
        height_r <= cfg_pwdata[wsfe_pkg::DIM_W-1:0];
      end else begin
        width_r <= cfg_pwdata[wsfe_pkg::DIM_W-1:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == wsfe_pkg::REG_WIDTH)
                      ? wsfe_pkg::CFG_DW'(width_r) : wsfe_pkg::CFG_DW'(height_r);

  wsfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat_i   (dp_stat),
    .cmd_o    (ctrl_cmd)
  );

  wsfe_dp #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .cmd_i      (ctrl_cmd),
    .stat_o     (dp_stat),
    .width_reg  (width_r),
    .height_reg (height_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

`include "ws2812_frame_encoder_assert.svh"

  `WSFE_ASSERT_NXT(a_accept_drops_ready, in_valid && in_ready, !in_ready, "ready stayed high after an accepted transaction")
  `WSFE_ASSERT_IMP(a_sweep_blocks_input, ctrl_cmd.clr || ctrl_cmd.init_clr, !in_ready, "input accepted during a store sweep")
  `WSFE_ASSERT_IMP(a_out_load_free, ctrl_cmd.out_load, dp_stat.out_free, "result loaded over an undelivered result")

endmodule
